[rtl/frame_delta_skip_copy_encoder_macros.svh]
// Assertion macros used by the encoder's datapath RTL file.
`ifndef FRAME_DELTA_SKIP_COPY_ENCODER_MACROS_SVH
`define FRAME_DELTA_SKIP_COPY_ENCODER_MACROS_SVH

`ifndef ASSERT_OFF
`define FDSC_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define FDSC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define FDSC_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define FDSC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

[rtl/fdsc_pkg.sv]
package fdsc_pkg;

   localparam int unsigned RUN_W   = 15;
   localparam int unsigned PIXEL_W = 24;
   localparam logic [RUN_W-1:0] SKIP_LIMIT = 15'h7fff;

   typedef enum logic [1:0] {
      KIND_SKIP  = 2'd0,
      KIND_COPY  = 2'd1,
      KIND_LIT   = 2'd2,
      KIND_COUNT = 2'd3
   } item_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_TOKEN,
      ST_READ,
      ST_LITERAL,
      ST_COUNT
   } state_type;

   typedef struct packed {
      logic capture;
      logic append;
      logic close;
      logic load_token;
      logic load_literal;
      logic load_count;
      logic read;
      logic last_of_run;
   } cmd_type;

   typedef struct packed {
      logic need_close;
      logic run_copy;
      logic lit_last;
      logic out_free;
      logic last_item;
   } status_type;

   function automatic logic [PIXEL_W-1:0] to_xrgb(input logic [31:0] raw,
                                                  input logic rgb565);
      logic [4:0] r;
      logic [5:0] g;
      logic [4:0] b;
      r = raw[15:11];
      g = raw[10:5];
      b = raw[4:0];
      if (rgb565) begin
         to_xrgb = {r, r[4:2], g, g[5:4], b, b[4:2]};
      end else begin
         to_xrgb = raw[PIXEL_W-1:0];
      end
   endfunction

endpackage

[rtl/fdsc_ctrl.sv]
module fdsc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  fdsc_pkg::status_type status,
   output fdsc_pkg::cmd_type    cmd
);

   fdsc_pkg::state_type state_ff, state_in;
   logic                final_ff, final_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fdsc_pkg::ST_IDLE;
         final_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         final_ff <= final_in;
      end
   end

   assign req_stall = (state_ff != fdsc_pkg::ST_IDLE);

   always_comb begin
      logic end_run;
      end_run  = 1'b0;
      state_in = state_ff;
      final_in = final_ff;
      cmd      = '0;
      case (state_ff)
         fdsc_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = fdsc_pkg::ST_EVAL;
            end
         end
         fdsc_pkg::ST_EVAL: begin
            if (status.need_close) begin
               final_in = 1'b0;
               state_in = fdsc_pkg::ST_TOKEN;
            end else begin
               cmd.append = 1'b1;
               if (status.last_item) begin
                  final_in = 1'b1;
                  state_in = fdsc_pkg::ST_TOKEN;
               end else begin
                  state_in = fdsc_pkg::ST_IDLE;
               end
            end
         end
         fdsc_pkg::ST_TOKEN: begin
            if (status.out_free) begin
               cmd.load_token = 1'b1;
               if (status.run_copy) begin
                  state_in = fdsc_pkg::ST_READ;
               end else begin
                  end_run = 1'b1;
               end
            end
         end
         fdsc_pkg::ST_READ: begin
            cmd.read = 1'b1;
            state_in = fdsc_pkg::ST_LITERAL;
         end
         fdsc_pkg::ST_LITERAL: begin
            if (status.out_free) begin
               cmd.load_literal = 1'b1;
               if (status.lit_last) begin
                  end_run = 1'b1;
               end else begin
                  state_in = fdsc_pkg::ST_READ;
               end
            end
         end
         fdsc_pkg::ST_COUNT: begin
            if (status.out_free) begin
               cmd.load_count  = 1'b1;
               cmd.last_of_run = 1'b1;
               state_in        = fdsc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fdsc_pkg::ST_IDLE;
         end
      endcase

      if (end_run) begin
         cmd.close = 1'b1;
         if (final_ff) begin
            state_in = fdsc_pkg::ST_COUNT;
         end else begin
            cmd.append      = 1'b1;
            cmd.last_of_run = !status.last_item;
            if (status.last_item) begin
               final_in = 1'b1;
               state_in = fdsc_pkg::ST_TOKEN;
            end else begin
               state_in = fdsc_pkg::ST_IDLE;
            end
         end
      end
   end

endmodule

[rtl/fdsc_datapath.sv]
`include "frame_delta_skip_copy_encoder_macros.svh"

module fdsc_datapath #(
   parameter int unsigned MAX_COPY_RUN = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic                   csr_source_is_rgb565,
   input  logic [31:0]            req_current_raw,
   input  logic [23:0]            req_previous_pixel,
   input  logic                   req_last_in_frame,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_item_kind,
   output logic [31:0]            rsp_item_value,
   output logic                   rsp_last_of_run,
   input  fdsc_pkg::cmd_type      cmd,
   output fdsc_pkg::status_type   status
);

   localparam int unsigned DEPTH = MAX_COPY_RUN;
   localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [fdsc_pkg::RUN_W-1:0] MAX_RUN_LEN = fdsc_pkg::RUN_W'(MAX_COPY_RUN);

   logic                              rgb565_ff;
   logic [fdsc_pkg::PIXEL_W-1:0]      px_ff;
   logic                              copy_ff;
   logic                              last_ff;

   logic                              open_ff, open_in;
   logic                              run_copy_ff, run_copy_in;
   logic [fdsc_pkg::RUN_W-1:0]        len_ff, len_in;
   logic [31:0]                       count_ff, count_in;
   logic [IDX_W-1:0]                  rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]                  wr_addr;
   logic [fdsc_pkg::RUN_W-1:0]        limit;
   logic [fdsc_pkg::PIXEL_W-1:0]      lit_mem [DEPTH];
   logic [fdsc_pkg::PIXEL_W-1:0]      rd_data_ff;

   logic                              out_valid_ff;
   fdsc_pkg::item_kind_type           out_kind_ff;
   logic [31:0]                       out_value_ff;
   logic                              out_last_ff;
   logic [fdsc_pkg::PIXEL_W-1:0]      px_in;

   assign px_in = fdsc_pkg::to_xrgb(req_current_raw, rgb565_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rgb565_ff <= 1'b0;
      end else if (csr_valid) begin
         rgb565_ff <= csr_source_is_rgb565;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         px_ff   <= px_in;
         copy_ff <= (px_in != req_previous_pixel);
         last_ff <= req_last_in_frame;
      end
   end

   assign limit   = copy_ff ? MAX_RUN_LEN : fdsc_pkg::SKIP_LIMIT;
   assign wr_addr = cmd.close ? '0 : len_ff[IDX_W-1:0];

   always_comb begin
      open_in     = open_ff;
      run_copy_in = run_copy_ff;
      len_in      = len_ff;
      count_in    = count_ff;
      rd_idx_in   = rd_idx_ff;
      if (cmd.close) begin
         open_in   = 1'b0;
         len_in    = '0;
         rd_idx_in = '0;
         if (run_copy_ff) begin
            count_in = count_ff + 32'd2 + {15'd0, len_ff, 2'b00};
         end else begin
            count_in = count_ff + 32'd2;
         end
      end else if (cmd.load_literal) begin
         rd_idx_in = rd_idx_ff + IDX_W'(1);
      end
      if (cmd.append) begin
         open_in     = 1'b1;
         run_copy_in = copy_ff;
         len_in      = cmd.close ? fdsc_pkg::RUN_W'(1) : len_ff + fdsc_pkg::RUN_W'(1);
      end
      if (cmd.load_count) begin
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff     <= 1'b0;
         run_copy_ff <= 1'b0;
         len_ff      <= '0;
         count_ff    <= '0;
         rd_idx_ff   <= '0;
      end else begin
         open_ff     <= open_in;
         run_copy_ff <= run_copy_in;
         len_ff      <= len_in;
         count_ff    <= count_in;
         rd_idx_ff   <= rd_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.append && copy_ff) begin
         lit_mem[wr_addr] <= px_ff;
      end
      if (cmd.read) begin
         rd_data_ff <= lit_mem[rd_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_token || cmd.load_literal || cmd.load_count) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_token) begin
         out_kind_ff  <= run_copy_ff ? fdsc_pkg::KIND_COPY : fdsc_pkg::KIND_SKIP;
         out_value_ff <= {16'h0000, run_copy_ff, len_ff};
         out_last_ff  <= cmd.last_of_run;
      end else if (cmd.load_literal) begin
         out_kind_ff  <= fdsc_pkg::KIND_LIT;
         out_value_ff <= {8'h00, rd_data_ff};
         out_last_ff  <= cmd.last_of_run;
      end else if (cmd.load_count) begin
         out_kind_ff  <= fdsc_pkg::KIND_COUNT;
         out_value_ff <= count_ff;
         out_last_ff  <= cmd.last_of_run;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_item_kind   = out_kind_ff;
   assign rsp_item_value  = out_value_ff;
   assign rsp_last_of_run = out_last_ff;

   assign status.need_close = open_ff && ((run_copy_ff != copy_ff) || (len_ff >= limit));
   assign status.run_copy   = run_copy_ff;
   assign status.lit_last   = ((fdsc_pkg::RUN_W'(rd_idx_ff) + fdsc_pkg::RUN_W'(1)) == len_ff);
   assign status.out_free   = !out_valid_ff || !rsp_stall;
   assign status.last_item  = last_ff;

   `FDSC_ASSERT_IMPLY(a_copy_len_bound, clock, reset, open_ff && run_copy_ff, len_ff <= MAX_RUN_LEN)
   `FDSC_ASSERT_IMPLY(a_load_when_free, clock, reset, cmd.load_token || cmd.load_literal || cmd.load_count, status.out_free)
   `FDSC_ASSERT_IMPLY(a_read_in_copy, clock, reset, cmd.read, open_ff && run_copy_ff)
   `FDSC_ASSERT_NEXT(a_count_cleared, clock, reset, cmd.load_count, count_ff == 32'd0)

endmodule

[rtl/frame_delta_skip_copy_encoder.sv]
// Frame delta encoder: compares each source pixel with the previous frame's
// pixel and emits SKIP/COPY run tokens, the COPY literals and, at frame end,
// the frame's op byte count.
// req_ channel: one pixel per transfer (req_valid high, req_stall low).
// rsp_ channel: one token, literal or count per transfer; rsp_last_of_run
// marks the last result caused by an input pixel.
// csr_ channel: writes source_is_rgb565; always ready, write only while idle.
// A pixel that extends the open run is accepted, then the open run is updated.
// Closing a run loads the token and then each literal in turn, since each
// literal is a registered read of the literal memory followed by the
// load of the output register; frame end then adds the count.
// Results leave through one output register; the first result of a pixel
// is loaded after the evaluate and token states, once that register is free.
// A stalled output register holds its result and pauses the controller;
// req_stall stays high until all results of the pixel are loaded.
// Reset (synchronous, active high) closes any run, clears the byte count
// and the output; the literal memory is not cleared.
module frame_delta_skip_copy_encoder #(
   parameter int unsigned MAX_COPY_RUN = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_source_is_rgb565,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_current_raw,
   input  logic [23:0] req_previous_pixel,
   input  logic        req_last_in_frame,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_item_kind,
   output logic [31:0] rsp_item_value,
   output logic        rsp_last_of_run
);

   fdsc_pkg::cmd_type    cmd;
   fdsc_pkg::status_type status;

   assign csr_ready = 1'b1;

   fdsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   fdsc_datapath #(
      .MAX_COPY_RUN (MAX_COPY_RUN)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_source_is_rgb565 (csr_source_is_rgb565),
      .req_current_raw      (req_current_raw),
      .req_previous_pixel   (req_previous_pixel),
      .req_last_in_frame    (req_last_in_frame),
      .rsp_stall            (rsp_stall),
      .rsp_valid            (rsp_valid),
      .rsp_item_kind        (rsp_item_kind),
      .rsp_item_value       (rsp_item_value),
      .rsp_last_of_run      (rsp_last_of_run),
      .cmd                  (cmd),
      .status               (status)
   );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

   localparam int CLK_PERIOD    = 10;
   localparam int MAX_COPY_RUN  = 32;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_ITEMS  = 250;
   localparam int RUN_LIMIT     = 1000000;

   typedef struct {
      fdsc_pkg::item_kind_type kind;
      logic [31:0]             value;
      logic                    last_of_run;
   } encoder_op_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_source_is_rgb565 = 1'b0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_current_raw = '0;
   logic [23:0] req_previous_pixel = '0;
   logic        req_last_in_frame = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_item_kind;
   logic [31:0] rsp_item_value;
   logic        rsp_last_of_run;

   // encoder state as seen by the predictor
   logic        mode_rgb565 = 1'b0;
   logic        run_active = 1'b0;
   logic        run_changed = 1'b0;
   int          run_len = 0;
   logic [23:0] literal_buf [32];
   logic [31:0] frame_bytes = '0;

   encoder_op_type pending_ops [$];
   encoder_op_type pixel_ops [$];
   encoder_op_type next_op;

   int req_gap_max = 11;
   int rsp_gap_max = 11;
   int rsp_wait_left = 0;
   int rsp_hold_cycles = 0;
   int fail_count = 0;
   int cycle_count = 0;

   frame_delta_skip_copy_encoder #(
      .MAX_COPY_RUN(MAX_COPY_RUN)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_source_is_rgb565(csr_source_is_rgb565),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_current_raw(req_current_raw),
      .req_previous_pixel(req_previous_pixel),
      .req_last_in_frame(req_last_in_frame),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item_kind(rsp_item_kind),
      .rsp_item_value(rsp_item_value),
      .rsp_last_of_run(rsp_last_of_run)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic logic [23:0] to_rgb888(input logic [31:0] raw);
      if (mode_rgb565) begin
         return {raw[15:11], raw[15:13], raw[10:5], raw[10:9], raw[4:0], raw[4:2]};
      end
      return raw[23:0];
   endfunction

   task automatic close_open_run();
      encoder_op_type op;
      int k;
      if (!run_active) return;
      op.last_of_run = 1'b0;
      if (run_changed) begin
         op.kind = fdsc_pkg::KIND_COPY;
         op.value = 32'h8000 | 32'(run_len);
         pixel_ops.push_back(op);
         for (k = 0; k < run_len; k++) begin
            op.kind = fdsc_pkg::KIND_LIT;
            op.value = {8'h00, literal_buf[k]};
            pixel_ops.push_back(op);
         end
         frame_bytes = frame_bytes + 32'(2 + 4 * run_len);
      end else begin
         op.kind = fdsc_pkg::KIND_SKIP;
         op.value = 32'(run_len);
         pixel_ops.push_back(op);
         frame_bytes = frame_bytes + 32'd2;
      end
      run_active = 1'b0;
      run_len = 0;
   endtask

   task automatic encode_pixel(input logic [31:0] raw, input logic [23:0] prev,
                               input logic last);
      logic [23:0]    px;
      logic           changed;
      int             cap;
      encoder_op_type op;
      px = to_rgb888(raw);
      changed = (px != prev);
      cap = changed ? MAX_COPY_RUN : int'(fdsc_pkg::SKIP_LIMIT);
      if (!(run_active && run_changed == changed && run_len < cap)) begin
         close_open_run();
         run_active = 1'b1;
         run_changed = changed;
         run_len = 0;
      end
      if (changed) literal_buf[run_len % 32] = px;
      run_len++;
      if (last) begin
         close_open_run();
         op.kind = fdsc_pkg::KIND_COUNT;
         op.value = frame_bytes;
         op.last_of_run = 1'b0;
         pixel_ops.push_back(op);
         frame_bytes = '0;
      end
      foreach (pixel_ops[i]) begin
         op = pixel_ops[i];
         op.last_of_run = (i == pixel_ops.size() - 1);
         pending_ops.push_back(op);
      end
      pixel_ops.delete();
   endtask

   task automatic send_pixel(input logic [31:0] raw, input logic [23:0] prev,
                             input logic last);
      int gap;
      gap = $urandom_range(req_gap_max, 0);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_current_raw <= raw;
      req_previous_pixel <= prev;
      req_last_in_frame <= last;
      do @(posedge clock); while (req_stall);
      encode_pixel(raw, prev, last);
   endtask

   task automatic draw_pixel_pair(input logic changed, output logic [31:0] raw,
                                  output logic [23:0] prev);
      logic [23:0] px;
      raw = $urandom();
      px = to_rgb888(raw);
      if (changed) begin
         prev = 24'($urandom());
         if (prev == px) prev = ~px;
      end else begin
         prev = px;
      end
   endtask

   task automatic settle_encoder();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_ops.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_source_mode(input logic rgb565);
      settle_encoder();
      csr_valid <= 1'b1;
      csr_source_is_rgb565 <= rgb565;
      do @(posedge clock); while (!csr_ready);
      mode_rgb565 = rgb565;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // hold off results, then draw a fresh wait after every transfer
   always begin
      @(negedge clock);
      if (rsp_hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold_cycles--;
      end else if (rsp_wait_left > 0) begin
         rsp_stall <= 1'b1;
         rsp_wait_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_ops.size() == 0) begin
            $error("unexpected transfer kind %0d value %h", rsp_item_kind, rsp_item_value);
            fail_count++;
         end else begin
            next_op = pending_ops.pop_front();
            if (rsp_item_kind !== next_op.kind) begin
               $error("item_kind expected %0d actual %0d", next_op.kind, rsp_item_kind);
               fail_count++;
            end
            if (rsp_item_value !== next_op.value) begin
               $error("item_value expected %h actual %h", next_op.value, rsp_item_value);
               fail_count++;
            end
            if (rsp_last_of_run !== next_op.last_of_run) begin
               $error("last_of_run expected %0d actual %0d", next_op.last_of_run,
                      rsp_last_of_run);
               fail_count++;
            end
         end
         rsp_wait_left = $urandom_range(rsp_gap_max, 0);
      end
   end

   task automatic test_argb_basics();
      send_pixel(32'hffff_ffff, 24'hff_ffff, 1'b0);
      send_pixel(32'h0000_0000, 24'h00_0000, 1'b0);
      send_pixel(32'h80ff_00ff, 24'h00_0000, 1'b0);
      send_pixel(32'h7f00_0001, 24'hff_ffff, 1'b0);
      send_pixel(32'h00ff_ffff, 24'hff_ffff, 1'b1);
   endtask

   task automatic test_single_pixel_frames();
      send_pixel(32'h1234_5678, 24'h34_5678, 1'b1);
      send_pixel(32'h1234_5678, 24'h00_0000, 1'b1);
   endtask

   task automatic test_rgb565_widening();
      write_source_mode(1'b1);
      send_pixel(32'hffff_ffff, 24'hff_ffff, 1'b0);
      send_pixel(32'habcd_0000, 24'h00_0000, 1'b0);
      send_pixel(32'h0000_f800, 24'h00_0000, 1'b0);
      send_pixel(32'h0000_07e0, 24'h00_0000, 1'b0);
      send_pixel(32'h0000_001f, 24'h00_0000, 1'b0);
      send_pixel(32'h0000_0841, 24'h08_0808, 1'b1);
   endtask

   task automatic test_mode_switch_mid_frame();
      send_pixel(32'h0000_ffff, 24'hff_ffff, 1'b0);
      write_source_mode(1'b0);
      send_pixel(32'h0000_ffff, 24'hff_ffff, 1'b0);
      send_pixel(32'hff00_ffff, 24'h00_ffff, 1'b1);
   endtask

   task automatic test_copy_run_full();
      logic [31:0] raw;
      logic [23:0] prev;
      int k;
      for (k = 0; k < MAX_COPY_RUN; k++) begin
         draw_pixel_pair(1'b1, raw, prev);
         send_pixel(raw, prev, 1'b0);
      end
      draw_pixel_pair(1'b1, raw, prev);
      send_pixel(raw, prev, 1'b1);
   endtask

   task automatic test_output_backpressure();
      logic [31:0] raw;
      logic [23:0] prev;
      int k;
      settle_encoder();
      req_gap_max = 0;
      rsp_gap_max = 3;
      rsp_hold_cycles = 400;
      for (k = 0; k < 70; k++) begin
         draw_pixel_pair(k % 9 != 8, raw, prev);
         send_pixel(raw, prev, k == 69);
      end
   endtask

   task automatic test_random_frames();
      logic [31:0] raw;
      logic [23:0] prev;
      logic        changed;
      int          sent;
      int          frame_len;
      int          run_left;
      int          k;
      sent = 0;
      changed = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(3, 0) == 0) write_source_mode(1'($urandom_range(1, 0)));
         req_gap_max = ($urandom_range(2, 0) == 0) ? 0 : 11;
         rsp_gap_max = ($urandom_range(2, 0) == 0) ? 0 : 11;
         frame_len = $urandom_range(60, 1);
         run_left = 0;
         for (k = 0; k < frame_len; k++) begin
            if (run_left == 0) begin
               changed = 1'($urandom_range(1, 0));
               run_left = ($urandom_range(7, 0) == 0) ? $urandom_range(40, 30)
                                                      : $urandom_range(8, 1);
            end
            if ($urandom_range(9, 0) == 0) begin
               raw = $urandom();
               prev = 24'($urandom());
            end else begin
               draw_pixel_pair(changed, raw, prev);
            end
            send_pixel(raw, prev, k == frame_len - 1);
            run_left--;
         end
         sent += frame_len;
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_argb_basics();
      test_single_pixel_frames();
      test_rgb565_widening();
      test_mode_switch_mid_frame();
      test_copy_run_full();
      test_output_backpressure();
      test_random_frames();
      write_source_mode(1'b1);
      test_copy_run_full();
      settle_encoder();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending_ops.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl
rtl/fdsc_pkg.sv
rtl/fdsc_ctrl.sv
rtl/fdsc_datapath.sv
rtl/frame_delta_skip_copy_encoder.sv
tb/tb_top.sv
